/* sv/hrpm_pkg.sv */
// hrpm_pkg: shared types and constants of the hue ramp pseudocolor mapper
`timescale 1ns / 1ps
package hrpm_pkg;

  // fixed formats
  localparam int unsigned CoordWidth   = 16;
  localparam int unsigned HueFracBits  = 8;
  localparam int unsigned HueWidth     = 17;  // 360 << 8 needs 17 bits
  localparam int unsigned NumWidth     = 31;  // dividend of the height ramp
  localparam int unsigned RadWidth     = 34;  // radicand of the distance ramp
  localparam int unsigned IterSteps    = 17;  // quotient and root bits

  // Q8.8 constants; QTenSq is ten squared in Q16.16 and HueSixty is a Q9.8 hue
  localparam logic signed [CoordWidth:0] QFive = 17'sd1280;
  localparam logic signed [CoordWidth:0] QTen  = 17'sd2560;
  localparam logic [24:0]                QTenSq = 25'd6553600;
  localparam logic [HueWidth-1:0]        HueSixty = 17'd15360;

  // configuration register indexes
  localparam logic [2:0] RegMapMode    = 3'd0;
  localparam logic [2:0] RegAxisSelect = 3'd1;
  localparam logic [2:0] RegMinHeight  = 3'd2;
  localparam logic [2:0] RegMaxHeight  = 3'd3;
  localparam logic [2:0] RegRefX       = 3'd4;
  localparam logic [2:0] RegRefY       = 3'd5;
  localparam logic [2:0] RegRefZ       = 3'd6;

  // map modes
  localparam logic [1:0] ModeCoord    = 2'd0;
  localparam logic [1:0] ModeHeight   = 2'd1;
  localparam logic [1:0] ModeDist     = 2'd2;
  localparam logic [1:0] ModeReserved = 2'd3;

  // axis codes
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  // where the hue of an item comes from
  typedef enum logic [2:0] {
    SRC_HUE,
    SRC_DIV,
    SRC_ROOT,
    SRC_RED,
    SRC_BLUE,
    SRC_BLACK
  } src_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pos_x;
    logic signed [CoordWidth-1:0] pos_y;
    logic signed [CoordWidth-1:0] pos_z;
    logic signed [CoordWidth-1:0] height;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_word_t;

  // state carried through the divide and square root steps
  typedef struct packed {
    src_e                  src;
    logic [HueWidth-1:0]   hue_direct;
    logic [15:0]           range;
    logic [IterSteps-1:0]  num;
    logic [15:0]           drem;
    logic [IterSteps-1:0]  quo;
    logic [RadWidth-1:0]   rad;
    logic [18:0]           srem;
    logic [IterSteps-1:0]  root;
  } iter_t;

endpackage

/* sv/hrpm_step.sv */
// hrpm_step: one registered step of the restoring divider and the square root
`timescale 1ns / 1ps
module hrpm_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  hrpm_pkg::iter_t   data_i,
  output logic              valid_o,
  output hrpm_pkg::iter_t   data_o
);

  hrpm_pkg::iter_t d_d, d_q;
  logic            valid_q;
  logic [16:0]     dsh;
  logic [20:0]     rem4;
  logic [20:0]     trial;

  // one quotient bit and one root bit
  always_comb begin
    d_d  = data_i;
    dsh  = {data_i.drem, data_i.num[16]};
    d_d.num = {data_i.num[15:0], 1'b0};
    if (dsh >= {1'b0, data_i.range}) begin
      d_d.drem = 16'(dsh - {1'b0, data_i.range});
      d_d.quo  = {data_i.quo[15:0], 1'b1};
    end else begin
      d_d.drem = dsh[15:0];
      d_d.quo  = {data_i.quo[15:0], 1'b0};
    end
    rem4  = {data_i.srem, data_i.rad[33:32]};
    trial = {2'b00, data_i.root, 2'b01};
    d_d.rad = {data_i.rad[31:0], 2'b00};
    if (rem4 >= trial) begin
      d_d.srem = 19'(rem4 - trial);
      d_d.root = {data_i.root[15:0], 1'b1};
    end else begin
      d_d.srem = rem4[18:0];
      d_d.root = {data_i.root[15:0], 1'b0};
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // step data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = d_q;

endmodule

/* sv/hue_ramp_pseudocolor_mapper_unit.sv */
// hue_ramp_pseudocolor_mapper_unit: top level of the hue ramp pseudocolor mapper
`timescale 1ns / 1ps
// Turns each point word into one RGB word from a saturated hue ramp. One word is
// taken every cycle while the output is not held; the pipe has three setup stages,
// seventeen divide and square root steps (one quotient and one root bit each),
// a hue stage and the color output register. The whole pipe advances together
// and holds when the output word is not taken. Write configuration only while idle.
module hue_ramp_pseudocolor_mapper_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hrpm_pkg::in_word_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hrpm_pkg::out_word_t   out_data_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [15:0]           cfg_data_i
);

  localparam int unsigned Steps = hrpm_pkg::IterSteps;

  logic en;

  // configuration registers
  logic [1:0]         map_mode_q, axis_select_q;
  logic signed [15:0] min_height_q, max_height_q, ref_x_q, ref_y_q, ref_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_mode_q    <= hrpm_pkg::ModeCoord;
      axis_select_q <= hrpm_pkg::AxisZ;
      min_height_q  <= 16'sd0;
      max_height_q  <= 16'sd2560;
      ref_x_q       <= 16'sd0;
      ref_y_q       <= 16'sd0;
      ref_z_q       <= 16'sd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hrpm_pkg::RegMapMode:    map_mode_q    <= cfg_data_i[1:0];
        hrpm_pkg::RegAxisSelect: axis_select_q <= cfg_data_i[1:0];
        hrpm_pkg::RegMinHeight:  min_height_q  <= cfg_data_i;
        hrpm_pkg::RegMaxHeight:  max_height_q  <= cfg_data_i;
        hrpm_pkg::RegRefX:       ref_x_q       <= cfg_data_i;
        hrpm_pkg::RegRefY:       ref_y_q       <= cfg_data_i;
        hrpm_pkg::RegRefZ:       ref_z_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipe moves unless the output word is held
  assign en         = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  // stage 1: select source, clamp, differences
  hrpm_pkg::src_e     src1_d, src1_q;
  logic [16:0]        hue1_d, hue1_q;
  logic [15:0]        range1_d, range1_q, rd1_d, rd1_q;
  logic [11:0]        ax1_d, ax1_q, ay1_d, ay1_q, az1_d, az1_q;
  logic               v1_q;
  logic signed [16:0] c_s, t_s, hdiff, span, dx, dy, dz;
  logic [15:0]        dclamp;

  function automatic logic [11:0] abs_clamp(input logic signed [16:0] v);
    logic signed [16:0] a;
    a = (v < 0) ? -v : v;
    if (a > hrpm_pkg::QTen) return 12'(hrpm_pkg::QTen);
    return a[11:0];
  endfunction

  always_comb begin
    case (axis_select_q)
      hrpm_pkg::AxisX: c_s = 17'(in_data_i.pos_x);
      hrpm_pkg::AxisY: c_s = 17'(in_data_i.pos_y);
      default:         c_s = 17'(in_data_i.pos_z);
    endcase
    t_s = c_s + hrpm_pkg::QFive;
    if (t_s < 0) t_s = '0;
    if (t_s > hrpm_pkg::QTen) t_s = hrpm_pkg::QTen;
    hue1_d = 17'(t_s[11:0] * 17'd24);

    span  = 17'(max_height_q) - 17'(min_height_q);
    hdiff = 17'(in_data_i.height) - 17'(min_height_q);
    range1_d = span[15:0];
    if (hdiff < 0) dclamp = '0;
    else if (hdiff > span) dclamp = span[15:0];
    else dclamp = hdiff[15:0];
    rd1_d = range1_d - dclamp;

    dx = 17'(in_data_i.pos_x) - 17'(ref_x_q);
    dy = 17'(in_data_i.pos_y) - 17'(ref_y_q);
    dz = 17'(in_data_i.pos_z) - 17'(ref_z_q);
    ax1_d = abs_clamp(dx);
    ay1_d = abs_clamp(dy);
    az1_d = abs_clamp(dz);

    case (map_mode_q)
      hrpm_pkg::ModeCoord:  src1_d = hrpm_pkg::SRC_HUE;
      hrpm_pkg::ModeHeight: src1_d = (max_height_q <= min_height_q) ?
                                     hrpm_pkg::SRC_BLUE : hrpm_pkg::SRC_DIV;
      hrpm_pkg::ModeDist:   src1_d = hrpm_pkg::SRC_ROOT;
      default:              src1_d = hrpm_pkg::SRC_BLACK;
    endcase
  end

  // stage 2: squares and dividend
  hrpm_pkg::src_e src2_q;
  logic [16:0]    hue2_q;
  logic [15:0]    range2_q;
  logic [23:0]    sx2_q, sy2_q, sz2_q;
  logic [30:0]    num2_q;
  logic           v2_q;

  // stage 3: sum, far test, radicand
  hrpm_pkg::iter_t it3_d, it3_q;
  logic            v3_q;
  logic [24:0]     ssum;

  always_comb begin
    ssum = 25'(sx2_q) + 25'(sy2_q) + 25'(sz2_q);
    it3_d = '0;
    it3_d.src        = src2_q;
    it3_d.hue_direct = hue2_q;
    it3_d.range      = range2_q;
    it3_d.num        = num2_q[16:0];
    it3_d.drem       = {2'b00, num2_q[30:17]};
    it3_d.rad        = 34'(ssum) * 34'd1296;
    if (src2_q == hrpm_pkg::SRC_ROOT && ssum >= hrpm_pkg::QTenSq) begin
      it3_d.src = hrpm_pkg::SRC_RED;
    end
  end

  // front stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // front stage data
  always_ff @(posedge clk_i) begin
    if (en) begin
      src1_q   <= src1_d;
      hue1_q   <= hue1_d;
      range1_q <= range1_d;
      rd1_q    <= rd1_d;
      ax1_q    <= ax1_d;
      ay1_q    <= ay1_d;
      az1_q    <= az1_d;
      src2_q   <= src1_q;
      hue2_q   <= hue1_q;
      range2_q <= range1_q;
      sx2_q    <= 24'(ax1_q) * 24'(ax1_q);
      sy2_q    <= 24'(ay1_q) * 24'(ay1_q);
      sz2_q    <= 24'(az1_q) * 24'(az1_q);
      num2_q   <= 31'(rd1_q * 31'd30720);
      it3_q    <= it3_d;
    end
  end

  // divide and square root steps
  hrpm_pkg::iter_t it_s [Steps+1];
  logic            v_s  [Steps+1];

  assign it_s[0] = it3_q;
  assign v_s[0]  = v3_q;

  for (genvar g = 0; g < Steps; g++) begin : g_step
    hrpm_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_s[g]),
      .data_i  (it_s[g]),
      .valid_o (v_s[g+1]),
      .data_o  (it_s[g+1])
    );
  end

  // hue stage
  hrpm_pkg::iter_t it_end;
  hrpm_pkg::src_e  srch_q;
  logic [16:0]     hue_d, hue_q;
  logic            vh_q;

  assign it_end = it_s[Steps];

  always_comb begin
    case (it_end.src)
      hrpm_pkg::SRC_HUE:  hue_d = it_end.hue_direct;
      hrpm_pkg::SRC_DIV:  hue_d = it_end.quo;
      hrpm_pkg::SRC_ROOT: hue_d = it_end.root;
      default:            hue_d = '0;
    endcase
  end

  // color stage
  hrpm_pkg::out_word_t rgb_d, out_q;
  logic                vo_q;
  logic [2:0]          sector;
  logic [16:0]         rem;
  logic [7:0]          up, down;
  logic [20:0]         up_p, down_p;

  always_comb begin
    if (hue_q >= 17'(5 * 15360)) begin
      sector = 3'd5; rem = hue_q - 17'(5 * 15360);
    end else if (hue_q >= 17'(4 * 15360)) begin
      sector = 3'd4; rem = hue_q - 17'(4 * 15360);
    end else if (hue_q >= 17'(3 * 15360)) begin
      sector = 3'd3; rem = hue_q - 17'(3 * 15360);
    end else if (hue_q >= 17'(2 * 15360)) begin
      sector = 3'd2; rem = hue_q - 17'(2 * 15360);
    end else if (hue_q >= hrpm_pkg::HueSixty) begin
      sector = 3'd1; rem = hue_q - hrpm_pkg::HueSixty;
    end else begin
      sector = 3'd0; rem = hue_q;
    end
    // rem * 255 / 15360 is rem * 17 / 1024
    up_p   = 21'(rem[13:0] * 21'd17);
    down_p = 21'((hrpm_pkg::HueSixty - rem) * 21'd17);
    up     = up_p[17:10];
    down   = down_p[17:10];
    case (sector)
      3'd0:    rgb_d = '{red: 8'd255, green: up,     blue: 8'd0};
      3'd1:    rgb_d = '{red: down,   green: 8'd255, blue: 8'd0};
      3'd2:    rgb_d = '{red: 8'd0,   green: 8'd255, blue: up};
      3'd3:    rgb_d = '{red: 8'd0,   green: down,   blue: 8'd255};
      3'd4:    rgb_d = '{red: up,     green: 8'd0,   blue: 8'd255};
      default: rgb_d = '{red: 8'd255, green: 8'd0,   blue: down};
    endcase
    case (srch_q)
      hrpm_pkg::SRC_BLUE:  rgb_d = '{red: 8'd0, green: 8'd0, blue: 8'd255};
      hrpm_pkg::SRC_BLACK: rgb_d = '{red: 8'd0, green: 8'd0, blue: 8'd0};
      default: ;
    endcase
  end

  // back stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      vh_q <= v_s[Steps];
      vo_q <= vh_q;
    end
  end

  // back stage data
  always_ff @(posedge clk_i) begin
    if (en) begin
      srch_q <= it_end.src;
      hue_q  <= hue_d;
      out_q  <= rgb_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

/* dv/hue_ramp_pseudocolor_mapper_unit_test.sv */
// hue_ramp_pseudocolor_mapper_unit_test: self-checking testbench of the pseudocolor mapper
`timescale 1ns / 1ps
module hue_ramp_pseudocolor_mapper_unit_test;

  localparam int unsigned PipeDepth = 22;
  localparam int unsigned StallLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  hrpm_pkg::in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  hrpm_pkg::out_word_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  // predictor copy of the registers
  logic [1:0] mode_q, axis_q;
  logic signed [15:0] lo_q, hi_q, rx_q, ry_q, rz_q;

  hrpm_pkg::out_word_t color_fifo[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_bursty = 1'b1;
  bit tx_bursty = 1'b1;
  bit rx_hold = 1'b0;

  hue_ramp_pseudocolor_mapper_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned res, bit_v;
    res = 64'd0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic hrpm_pkg::out_word_t hue_color(longint unsigned hue);
    longint unsigned sec, rem, up, dn, six;
    hrpm_pkg::out_word_t c;
    six = 64'd60 << 8;
    hue = hue % (64'd360 << 8);
    sec = hue / six;
    rem = hue - sec * six;
    up = rem * 64'd255 / six;
    dn = (six - rem) * 64'd255 / six;
    case (sec)
      64'd0: c = '{8'd255, up[7:0], 8'd0};
      64'd1: c = '{dn[7:0], 8'd255, 8'd0};
      64'd2: c = '{8'd0, 8'd255, up[7:0]};
      64'd3: c = '{8'd0, dn[7:0], 8'd255};
      64'd4: c = '{up[7:0], 8'd0, 8'd255};
      default: c = '{8'd255, 8'd0, dn[7:0]};
    endcase
    return c;
  endfunction

  function automatic longint unsigned dist_term(longint d);
    longint unsigned a;
    a = (d < 0) ? longint'(-d) : d;
    return (a > 64'd2560) ? 64'd2560 : a;
  endfunction

  function automatic hrpm_pkg::out_word_t predict_color(hrpm_pkg::in_word_t w);
    longint c, t, rng, df;
    longint unsigned s, ax, ay, az;
    case (mode_q)
      hrpm_pkg::ModeCoord: begin
        c = (axis_q == hrpm_pkg::AxisX) ? longint'(w.pos_x) :
            (axis_q == hrpm_pkg::AxisY) ? longint'(w.pos_y) : longint'(w.pos_z);
        t = c + 64'sd1280;
        if (t < 0) t = 0;
        if (t > 2560) t = 2560;
        return hue_color(((t * 240) << 8) / 2560);
      end
      hrpm_pkg::ModeHeight: begin
        if (hi_q <= lo_q) return '{8'd0, 8'd0, 8'd255};
        rng = longint'(hi_q) - longint'(lo_q);
        df = longint'(w.height) - longint'(lo_q);
        if (df < 0) df = 0;
        if (df > rng) df = rng;
        return hue_color((((rng - df) * 120) << 8) / rng);
      end
      hrpm_pkg::ModeDist: begin
        ax = dist_term(longint'(w.pos_x) - longint'(rx_q));
        ay = dist_term(longint'(w.pos_y) - longint'(ry_q));
        az = dist_term(longint'(w.pos_z) - longint'(rz_q));
        s = ax * ax + ay * ay + az * az;
        if (s >= 64'd6553600) return hue_color(64'd360 << 8);
        return hue_color(sqrt_floor((s * 64'd81) << 16) / 64'd64);
      end
      default: return '0;
    endcase
  endfunction

  // wait until every word is back and the pipe is empty
  task automatic drain;
    while (color_fifo.size() != 0) @(negedge clk_i);
    repeat (PipeDepth + 4) @(negedge clk_i);
  endtask

  // register write, only while idle
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      hrpm_pkg::RegMapMode: mode_q = val[1:0];
      hrpm_pkg::RegAxisSelect: axis_q = val[1:0];
      hrpm_pkg::RegMinHeight: lo_q = val;
      hrpm_pkg::RegMaxHeight: hi_q = val;
      hrpm_pkg::RegRefX: rx_q = val;
      hrpm_pkg::RegRefY: ry_q = val;
      default: rz_q = val;
    endcase
  endtask

  // send one word, random gaps before it
  task automatic send_word(hrpm_pkg::in_word_t w);
    if (tx_bursty && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = w;
    color_fifo.push_back(predict_color(w));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(0, 3200)) - 1600);
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return 16'($signed($urandom_range(0, 6000)) - 3000);
    endcase
  endfunction

  function automatic hrpm_pkg::in_word_t rand_word();
    hrpm_pkg::in_word_t w;
    w.pos_x = rand_coord();
    w.pos_y = rand_coord();
    w.pos_z = rand_coord();
    w.height = rand_coord();
    return w;
  endfunction

  // coordinate mode over every axis, incl. axis three and clamp edges
  task automatic test_coord_ramp;
    logic signed [15:0] pts[7] = '{-16'sd32768, -16'sd1281, -16'sd1280, 16'sd0,
                                  16'sd1279, 16'sd1280, 16'sd32767};
    write_reg(hrpm_pkg::RegMapMode, 16'(hrpm_pkg::ModeCoord));
    for (int a = 0; a < 4; a++) begin
      write_reg(hrpm_pkg::RegAxisSelect, 16'(a));
      for (int i = 0; i < 3; i++) send_word('{pts[i*2], pts[i*2+1], pts[6-i], 16'h5a5a});
    end
    drain();
  endtask

  // height mode incl. empty range
  task automatic test_height_ramp;
    write_reg(hrpm_pkg::RegMapMode, 16'(hrpm_pkg::ModeHeight));
    send_word('{16'd0, 16'd0, 16'd0, -16'sd1});
    send_word('{16'd0, 16'd0, 16'd0, 16'sd1280});
    send_word('{16'd0, 16'd0, 16'd0, 16'sd32767});
    write_reg(hrpm_pkg::RegMinHeight, 16'h8000);
    write_reg(hrpm_pkg::RegMaxHeight, 16'h7fff);
    send_word('{16'd0, 16'd0, 16'd0, 16'h8000});
    send_word('{16'd0, 16'd0, 16'd0, 16'h0000});
    write_reg(hrpm_pkg::RegMinHeight, 16'd100);
    write_reg(hrpm_pkg::RegMaxHeight, 16'd100);
    send_word('{16'd0, 16'd0, 16'd0, 16'd100});
    drain();
  endtask

  // distance mode incl. far point and reserved mode
  task automatic test_dist_ramp;
    write_reg(hrpm_pkg::RegMapMode, 16'(hrpm_pkg::ModeDist));
    write_reg(hrpm_pkg::RegRefX, 16'h8000);
    write_reg(hrpm_pkg::RegRefY, 16'h7fff);
    write_reg(hrpm_pkg::RegRefZ, 16'd0);
    send_word('{16'h8000, 16'h7fff, 16'd0, 16'd0});
    send_word('{16'h7fff, 16'h8000, 16'h7fff, 16'd0});
    write_reg(hrpm_pkg::RegRefX, 16'd0);
    write_reg(hrpm_pkg::RegRefY, 16'd0);
    send_word('{16'd2559, 16'd0, 16'd0, 16'd0});
    send_word('{16'd1478, 16'd1478, 16'd1478, 16'd0});
    drain();
    write_reg(hrpm_pkg::RegMapMode, 16'(hrpm_pkg::ModeReserved));
    send_word('{16'd1, 16'd2, 16'd3, 16'd4});
    drain();
  endtask

  // random words under random settings
  task automatic test_random_mix;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(hrpm_pkg::RegMapMode, 16'($urandom_range(0, 3)));
      write_reg(hrpm_pkg::RegAxisSelect, 16'($urandom_range(0, 3)));
      write_reg(hrpm_pkg::RegMinHeight, rand_coord());
      write_reg(hrpm_pkg::RegMaxHeight, rand_coord());
      write_reg(hrpm_pkg::RegRefX, rand_coord());
      write_reg(hrpm_pkg::RegRefY, rand_coord());
      write_reg(hrpm_pkg::RegRefZ, rand_coord());
      if (ph == 7) begin
        tx_bursty = 1'b0;
        rx_bursty = 1'b0;
      end
      for (int i = 0; i < 50; i++) send_word(rand_word());
      drain();
    end
  endtask

  // long receiver hold so the pipe fills and stalls the input
  task automatic test_backpressure;
    write_reg(hrpm_pkg::RegMapMode, 16'(hrpm_pkg::ModeDist));
    fork
      begin
        rx_hold = 1'b1;
        repeat (80) @(negedge clk_i);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_word(rand_word());
    join
    drain();
  endtask

  // receiver idling
  always @(negedge clk_i) begin
    if (rx_hold) out_ready_i <= 1'b0;
    else if (rx_bursty && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
      out_ready_i <= !rx_hold;
    end else out_ready_i <= 1'b1;
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (color_fifo.size() == 0) begin
        $display("%t unexpected word, expected none actual %h", $realtime, out_data_o);
        errors++;
      end else begin
        hrpm_pkg::out_word_t e;
        e = color_fifo.pop_front();
        if (e.red !== out_data_o.red || e.green !== out_data_o.green
            || e.blue !== out_data_o.blue) begin
          $display("%t color mismatch expected %h actual %h", $realtime, e, out_data_o);
          errors++;
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni
        || color_fifo.size() == 0) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("hue_ramp_pseudocolor_mapper_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    mode_q = hrpm_pkg::ModeCoord;
    axis_q = hrpm_pkg::AxisZ;
    lo_q = 16'sd0;
    hi_q = 16'sd2560;
    rx_q = '0;
    ry_q = '0;
    rz_q = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_coord_ramp();
    test_height_ramp();
    test_dist_ramp();
    test_backpressure();
    test_random_mix();
    if (color_fifo.size() != 0) errors++;
    if (errors == 0) begin
      $display("hue_ramp_pseudocolor_mapper_unit_test OK");
    end else begin
      $display("hue_ramp_pseudocolor_mapper_unit_test NOT OK");
    end
    $finish;
  end
endmodule
